FILE: rtl/pgi_pkg.sv
// shared types and constants for the palette gradient interpolator
package pgi_pkg;

    // request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // result channel format
    localparam int          OUT_W   = 17;
    localparam int          OUT_MAX = 131071;

    // controller to datapath commands
    typedef struct packed {
        logic append;
        logic clear;
        logic load;
        logic mul;
        logic div_est;
        logic div_fix;
        logic rd_a;
        logic rd_b;
        logic prod;
        logic sum;
        logic emit_empty;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
    } t_stat;

endpackage

FILE: rtl/pgi_ram.sv
// generic single write port ram with registered read
module pgi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/pgi_ctrl.sv
// request sequencer for the palette gradient interpolator
module pgi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic [1:0]     i_req_type,
    input  pgi_pkg::t_stat i_stat,
    output pgi_pkg::t_cmd  o_cmd,
    output logic           busy
);
    import pgi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_RDA  = 3'd4;
    localparam logic [2:0] S_RDB  = 3'd5;
    localparam logic [2:0] S_PROD = 3'd6;
    localparam logic [2:0] S_SUM  = 3'd7;

    logic [2:0]     r_state, n_state;
    logic           accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_APPEND: o_cmd.append = 1'b1;
                        REQ_CLEAR:  o_cmd.clear  = 1'b1;
                        REQ_QUERY: begin
                            if (i_stat.empty) begin
                                o_cmd.emit_empty = 1'b1;
                            end else begin
                                o_cmd.load = 1'b1;
                                n_state    = S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_est = 1'b1;
                n_state       = S_FIX;
            end
            S_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = S_RDA;
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: rtl/pgi_dp.sv
// key store, index divider and blend arithmetic
module pgi_dp #(
    parameter int SMOOTH_ENTRIES = 256,
    parameter int MAX_KEYS       = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pgi_pkg::t_cmd               i_cmd,
    input  logic [7:0]                  i_red_in,
    input  logic [7:0]                  i_green_in,
    input  logic [7:0]                  i_blue_in,
    input  logic [7:0]                  i_entry_index,
    output pgi_pkg::t_stat              o_stat,
    output logic                        o_valid,
    output logic [pgi_pkg::OUT_W-1:0]   o_red_out,
    output logic [pgi_pkg::OUT_W-1:0]   o_green_out,
    output logic [pgi_pkg::OUT_W-1:0]   o_blue_out,
    output logic                        o_list_empty
);
    import pgi_pkg::*;

    localparam int KW    = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int PW    = 8 + KW;
    localparam int FW    = $clog2(SMOOTH_ENTRIES);
    localparam int RW    = FW + 1;
    localparam int PRW   = 8 + RW;
    localparam int SUMW  = (PRW + 1 > 18) ? PRW + 1 : 18;
    localparam int QW    = 2 * PW;
    localparam int MW    = PW + RW;
    // reciprocal scaled by 2^PW; the estimate is low by at most one
    localparam int RECIP = (1 << PW) / SMOOTH_ENTRIES;
    localparam int ONE_RAW = 256 * SMOOTH_ENTRIES;
    localparam int ONE     = (ONE_RAW > OUT_MAX) ? OUT_MAX : ONE_RAW;

    logic [CW-1:0]    r_count;
    logic [7:0]       r_idx;
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    r_q;
    logic [RW-1:0]    r_rem;
    logic [KW-1:0]    r_k2;
    logic [23:0]      r_c1;
    logic [PRW-1:0]   r_pa [3];
    logic [PRW-1:0]   r_pb [3];
    logic             r_valid;
    logic             r_empty;
    logic [OUT_W-1:0] r_out [3];

    logic [7:0]       idx_clamped;
    logic [KW-1:0]    cnt_m1;
    logic [QW-1:0]    est_prod;
    logic [MW-1:0]    rem_full;
    logic             rem_fix;
    logic [KW-1:0]    k_a;
    logic [CW-1:0]    k_p1;
    logic [KW-1:0]    k_b;
    logic [KW-1:0]    raddr;
    logic [23:0]      rdata;
    logic             we;

    assign o_stat.empty = (r_count == '0);

    // index clamp for entries past the end of the smooth palette
    assign idx_clamped = (32'(i_entry_index) >= SMOOTH_ENTRIES) ?
                         8'(SMOOTH_ENTRIES - 1) : i_entry_index;

    assign cnt_m1 = KW'(r_count - CW'(1));

    // quotient estimate by reciprocal multiply, then one remainder fix
    assign est_prod = QW'(r_p) * QW'(RECIP);
    assign rem_full = MW'(r_p) - MW'(r_q) * MW'(SMOOTH_ENTRIES);
    assign rem_fix  = (rem_full >= MW'(SMOOTH_ENTRIES));

    // key pair with clamp to the last key
    assign k_a  = (r_p >= PW'(r_count)) ? cnt_m1 : KW'(r_p);
    assign k_p1 = CW'(k_a) + CW'(1);
    assign k_b  = (k_p1 >= r_count) ? cnt_m1 : KW'(k_p1);

    assign raddr = i_cmd.rd_a ? k_a : r_k2;
    assign we    = i_cmd.append && (r_count < CW'(MAX_KEYS));

    pgi_ram #(
        .WIDTH (24),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (KW'(r_count)),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (we) begin
                r_count <= r_count + CW'(1);
            end
            r_valid <= i_cmd.sum || i_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= idx_clamped;
        end
        if (i_cmd.mul) begin
            r_p <= PW'(r_idx) * PW'(cnt_m1);
        end
        if (i_cmd.div_est) begin
            r_q <= est_prod[QW-1:PW];
        end
        // r_p takes the quotient, r_rem the remainder
        if (i_cmd.div_fix) begin
            r_p   <= rem_fix ? (r_q + PW'(1)) : r_q;
            r_rem <= rem_fix ? RW'(rem_full - MW'(SMOOTH_ENTRIES)) : RW'(rem_full);
        end
        if (i_cmd.rd_a) begin
            r_k2 <= k_b;
        end
        if (i_cmd.rd_b) begin
            r_c1 <= rdata;
        end
        if (i_cmd.prod) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_pa[ch] <= PRW'(r_c1[8*ch +: 8])
                          * PRW'(RW'(SMOOTH_ENTRIES) - r_rem);
                r_pb[ch] <= PRW'(rdata[8*ch +: 8]) * PRW'(r_rem);
            end
        end
        if (i_cmd.sum) begin
            for (int ch = 0; ch < 3; ch++) begin
                if ((SUMW'(r_pa[ch]) + SUMW'(r_pb[ch])) > SUMW'(OUT_MAX)) begin
                    r_out[ch] <= OUT_W'(OUT_MAX);
                end else begin
                    r_out[ch] <= OUT_W'(SUMW'(r_pa[ch]) + SUMW'(r_pb[ch]));
                end
            end
            r_empty <= 1'b0;
        end
        if (i_cmd.emit_empty) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out[ch] <= OUT_W'(ONE);
            end
            r_empty <= 1'b1;
        end
    end

    assign o_valid      = r_valid;
    assign o_red_out    = r_out[2];
    assign o_green_out  = r_out[1];
    assign o_blue_out   = r_out[0];
    assign o_list_empty = r_empty;
endmodule

FILE: rtl/palette_gradient_interpolator_top.sv
// top level: sequencer, key store datapath and result port
// append and clear leave busy low; a query on an empty list
// returns 1.0 with o_valid in the cycle after the request
// a query on a loaded list holds busy through multiply, quotient estimate,
// remainder fix, two key reads, blend products and sum; o_valid pulses in the
// first cycle with busy low, and start is ignored while busy; results never stall
// synchronous active-low reset empties the key list and idles the sequencer
module palette_gradient_interpolator_top #(
    parameter int SMOOTH_ENTRIES = 256,
    parameter int MAX_KEYS       = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_req_type,
    input  logic [7:0]                i_red_in,
    input  logic [7:0]                i_green_in,
    input  logic [7:0]                i_blue_in,
    input  logic [7:0]                i_entry_index,
    output logic                      o_valid,
    output logic [pgi_pkg::OUT_W-1:0] o_red_out,
    output logic [pgi_pkg::OUT_W-1:0] o_green_out,
    output logic [pgi_pkg::OUT_W-1:0] o_blue_out,
    output logic                      o_list_empty
);
    import pgi_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: decodes the request, walks multiply, divide, reads, blend
    pgi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // datapath: key store, divider, per-channel blend and output register
    pgi_dp #(
        .SMOOTH_ENTRIES (SMOOTH_ENTRIES),
        .MAX_KEYS       (MAX_KEYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_entry_index (i_entry_index),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_list_empty  (o_list_empty)
    );
endmodule
